### hdl/pcwe_pkg.sv
`timescale 1ns / 1ps

package pcwe_pkg;

	localparam logic [2:0] FUNC_WRITE    = 3'd0;
	localparam logic [2:0] FUNC_READ     = 3'd1;
	localparam logic [2:0] FUNC_PERIOD   = 3'd2;
	localparam logic [2:0] FUNC_ENVELOPE = 3'd3;
	localparam logic [2:0] FUNC_LENGTH   = 3'd4;
	localparam logic [2:0] FUNC_RESET    = 3'd5;

	localparam logic [7:0] ADDR_DUTY     = 8'h16;
	localparam logic [7:0] ADDR_ENVELOPE = 8'h17;
	localparam logic [7:0] ADDR_PERIOD   = 8'h18;
	localparam logic [7:0] ADDR_CONTROL  = 8'h19;

	localparam logic [11:0] PERIOD_WRAP  = 12'h800;
	localparam logic [6:0]  LENGTH_END   = 7'd64;
	localparam logic [3:0]  VOLUME_MAX   = 4'hF;
	localparam logic [7:0]  READ_IDLE    = 8'hFF;

	localparam logic [7:0] WAVE_TABLE [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] io_addr;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] sample_code;
		logic       dac_on;
	} rsp_t;

endpackage

### hdl/pcwe_stream_if.sv
`timescale 1ns / 1ps

interface pcwe_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/pulse_channel_with_envelope_unit.sv
`timescale 1ns / 1ps
// channel  dir  payload                            notes
// req      in   func, io_addr, write_data          bus access, tick or reset
// rsp      out  read_data, sample_code, dac_on     one per req transaction
//
// A new transaction is taken every cycle while the
// result register is empty or being drained. Each result is registered, valid in the cycle after.
// Channel state and the result register are updated in one pass.
// arst_n clears all channel state and the result valid flag.
// A stalled rsp holds req off (ready low) until it is taken.

module pulse_channel_with_envelope_unit
	import pcwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pcwe_stream_if.sink   req,
	pcwe_stream_if.source rsp
);

	logic fire;
	logic take_ok;
	rsp_t rsp_d;

	assign req.ready = take_ok;
	assign fire      = req.valid && take_ok;

	pcwe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req.payload),
		.rsp    (rsp_d)
	);

	pcwe_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rsp_d   (rsp_d),
		.take_ok (take_ok),
		.rsp     (rsp)
	);

endmodule

### hdl/pcwe_core.sv
`timescale 1ns / 1ps

module pcwe_core
	import pcwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	output rsp_t rsp
);

	typedef struct packed {
		logic [7:0]  duty_length;
		logic [7:0]  envelope;
		logic [7:0]  period_low;
		logic [7:0]  control;
		logic [11:0] period_count;
		logic [2:0]  duty_pos;
		logic [3:0]  volume;
		logic        rising;
		logic [2:0]  pace;
		logic [2:0]  env_count;
		logic [6:0]  length_count;
		logic        length_done;
		logic        dac_en;
	} chan_state_t;

	chan_state_t st_q;
	chan_state_t st_d;

	logic [11:0] period_inc;
	logic [2:0]  env_inc;
	logic [6:0]  length_inc;
	logic [7:0]  rd;
	logic [3:0]  vol_eff;
	logic [7:0]  pattern;

	assign period_inc = st_q.period_count + 12'd1;
	assign env_inc    = st_q.env_count + 3'd1;
	assign length_inc = st_q.length_count + 7'd1;

	always_comb begin
		st_d = st_q;
		rd   = READ_IDLE;
		unique case (req.func)
			FUNC_WRITE: begin
				if (req.io_addr == ADDR_DUTY) begin
					st_d.duty_length  = req.write_data;
					st_d.length_count = {1'b0, req.write_data[5:0]};
				end else if (req.io_addr == ADDR_ENVELOPE) begin
					st_d.envelope = req.write_data;
				end else if (req.io_addr == ADDR_PERIOD) begin
					st_d.period_low = req.write_data;
				end else if (req.io_addr == ADDR_CONTROL) begin
					st_d.control = req.write_data;
					if (req.write_data[7]) begin
						// retrigger
						st_d.length_count = {1'b0, st_q.duty_length[5:0]};
						st_d.length_done  = 1'b0;
						st_d.volume       = st_q.envelope[7:4];
						st_d.rising       = st_q.envelope[3];
						st_d.pace         = st_q.envelope[2:0];
						st_d.env_count    = 3'd0;
						st_d.dac_en       = |st_q.envelope[7:3];
						st_d.period_count = {1'b0, req.write_data[2:0], st_q.period_low};
					end
				end
			end
			FUNC_READ: begin
				if (req.io_addr == ADDR_DUTY) begin
					rd = st_q.duty_length | 8'h3F;
				end else if (req.io_addr == ADDR_ENVELOPE) begin
					rd = st_q.envelope;
				end else if (req.io_addr == ADDR_CONTROL) begin
					rd = (st_q.control & 8'h40) | 8'hBF;
				end
			end
			FUNC_PERIOD: begin
				if (period_inc == PERIOD_WRAP) begin
					st_d.period_count = {1'b0, st_q.control[2:0], st_q.period_low};
					st_d.duty_pos     = st_q.duty_pos + 3'd1;
				end else begin
					st_d.period_count = period_inc;
				end
			end
			FUNC_ENVELOPE: begin
				if (st_q.pace != 3'd0) begin
					if (env_inc == st_q.pace) begin
						st_d.env_count = 3'd0;
						if (st_q.rising && st_q.volume != VOLUME_MAX) begin
							st_d.volume = st_q.volume + 4'd1;
						end else if (!st_q.rising && st_q.volume != 4'd0) begin
							st_d.volume = st_q.volume - 4'd1;
						end
					end else begin
						st_d.env_count = env_inc;
					end
				end
			end
			FUNC_LENGTH: begin
				if (!st_q.length_done && st_q.control[6]) begin
					st_d.length_count = length_inc;
					if (length_inc == LENGTH_END) begin
						st_d.length_done = 1'b1;
					end
				end
			end
			FUNC_RESET: begin
				st_d.duty_length = 8'h00;
				st_d.envelope    = 8'h00;
				st_d.period_low  = 8'h00;
				st_d.control     = 8'h00;
				st_d.duty_pos    = 3'd0;
				st_d.dac_en      = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		pattern = WAVE_TABLE[st_d.duty_length[7:6]];
		vol_eff = (st_d.control[6] && st_d.length_done) ? 4'd0 : st_d.volume;
		rsp.read_data   = rd;
		rsp.sample_code = (st_d.dac_en && pattern[~st_d.duty_pos]) ? vol_eff : 4'd0;
		rsp.dac_on      = st_d.dac_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

endmodule

### hdl/pcwe_out_stage.sv
`timescale 1ns / 1ps

module pcwe_out_stage
	import pcwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  rsp_t rsp_d,
	output logic take_ok,
	pcwe_stream_if.source rsp
);

	logic valid_q;
	rsp_t data_q;

	assign take_ok     = !valid_q || rsp.ready;
	assign rsp.valid   = valid_q;
	assign rsp.payload = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= fire || (valid_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= rsp_d;
		end
	end

endmodule

### hdl/pcwe_checker.sv
`timescale 1ns / 1ps

module pcwe_checker
	import pcwe_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [2:0] req_func,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input rsp_t       rsp_payload
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("rsp payload changed while stalled");

	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result one cycle after transaction");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req stalled with empty result register");

	a_dac_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_payload.dac_on |-> rsp_payload.sample_code == 4'd0)
		else $error("sample code with DAC off");

	a_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func != FUNC_READ |=> rsp_payload.read_data == READ_IDLE)
		else $error("read data on non-read transaction");

endmodule

bind pulse_channel_with_envelope_unit pcwe_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_func    (req.payload.func),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
